/* rtl/core/wepd_pkg.sv */
// ----------------------------------------------------------------------------
// wepd_pkg
// Types, constants and microcode for the wheel encoder PID drive core.
// ----------------------------------------------------------------------------
package wepd_pkg;

  localparam int WHEELS    = 2;
  localparam int WIDX_W    = (WHEELS > 2) ? $clog2(WHEELS) : 1;

  localparam int ENC_W     = 16;
  localparam int TGT_W     = 16;
  localparam int BATT_W    = 14;
  localparam int GAIN_W    = 16;
  localparam int DUTY_W    = 10;
  localparam int POS_W     = 48;
  localparam int Q_W       = 32;
  localparam int DIFF_W    = Q_W + 1;
  localparam int SAT_IN_W  = Q_W + 2;

  localparam int MUL_A_W   = 34;
  localparam int MUL_B_W   = GAIN_W + 1;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = 36;
  localparam int MAG_W     = 17;
  localparam int FRAC_W    = 16;
  localparam int STEP_SH   = 8;

  localparam logic [MAG_W-1:0]   U_LIMIT   = MAG_W'(65536);
  localparam logic [MUL_B_W-1:0] DUTY_FULL = MUL_B_W'(1023);

  // configuration port
  localparam int APB_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_GAIN_PROP      = 3'd0,
    REG_GAIN_INTEG     = 3'd1,
    REG_GAIN_DERIV     = 3'd2,
    REG_SUM_LEAK       = 3'd3,
    REG_VELOCITY_SCALE = 3'd4,
    REG_LOW_BATTERY_MV = 3'd5
  } reg_idx_t;

  localparam logic [GAIN_W-1:0] RST_GAIN_PROP      = GAIN_W'(3932);
  localparam logic [GAIN_W-1:0] RST_GAIN_INTEG     = GAIN_W'(131);
  localparam logic [GAIN_W-1:0] RST_GAIN_DERIV     = GAIN_W'(13107);
  localparam logic [GAIN_W-1:0] RST_SUM_LEAK       = GAIN_W'(58982);
  localparam logic [GAIN_W-1:0] RST_VELOCITY_SCALE = GAIN_W'(28266);
  localparam logic [BATT_W-1:0] RST_LOW_BATTERY_MV = BATT_W'(3000);

  typedef struct packed {
    logic [GAIN_W-1:0] gain_prop;
    logic [GAIN_W-1:0] gain_integ;
    logic [GAIN_W-1:0] gain_deriv;
    logic [GAIN_W-1:0] sum_leak;
    logic [GAIN_W-1:0] velocity_scale;
    logic [BATT_W-1:0] low_battery_mv;
  } cfg_t;

  // sequencer
  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t UA_DELTA  = STEP_W'(0);
  localparam step_t UA_SETPT  = STEP_W'(1);
  localparam step_t UA_ERR    = STEP_W'(2);
  localparam step_t UA_PROP   = STEP_W'(3);
  localparam step_t UA_DERIV  = STEP_W'(4);
  localparam step_t UA_INTEG  = STEP_W'(5);
  localparam step_t UA_SUM    = STEP_W'(6);
  localparam step_t UA_CLAMP  = STEP_W'(7);
  localparam step_t UA_ESUM   = STEP_W'(8);
  localparam step_t UA_COMMIT = STEP_W'(9);
  localparam step_t UA_SKIP   = STEP_W'(10);
  localparam int    UCODE_LEN = 11;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_DELTA,
    DP_SETPT,
    DP_ERR,
    DP_DIFF,
    DP_SUM,
    DP_CLAMP,
    DP_ESUM,
    DP_COMMIT,
    DP_SKIP_EMIT
  } dp_op_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [2:0] {
    MA_TARGET,
    MA_ERR,
    MA_DIFF,
    MA_ESUM,
    MA_SUM,
    MA_MAG
  } mul_a_t;

  typedef enum logic [2:0] {
    MB_VSCALE,
    MB_PROP,
    MB_DERIV,
    MB_INTEG,
    MB_LEAK,
    MB_DUTY
  } mul_b_t;

  typedef enum logic {
    COND_NONE,
    COND_SKIP
  } cond_t;

  typedef struct packed {
    dp_op_t  dp_op;
    acc_op_t acc_op;
    logic    mul_en;
    mul_a_t  mul_a;
    mul_b_t  mul_b;
    cond_t   cond;
    step_t   target;
    logic    last;
  } uword_t;

  typedef struct packed {
    logic   idle;
    logic   exec;
    uword_t uw;
  } dp_ctl_t;

  typedef struct packed {
    logic in_valid;
    logic skip;
    logic out_busy;
  } dp_stat_t;

  // control store
  function automatic uword_t ucode_fetch(input step_t step);
    uword_t w;
    w.dp_op  = DP_NOP;
    w.acc_op = ACC_HOLD;
    w.mul_en = 1'b0;
    w.mul_a  = MA_TARGET;
    w.mul_b  = MB_VSCALE;
    w.cond   = COND_NONE;
    w.target = UA_DELTA;
    w.last   = 1'b0;
    case (step)
      UA_DELTA: begin
        w.dp_op  = DP_DELTA;
        w.mul_en = 1'b1;
        w.mul_a  = MA_TARGET;
        w.mul_b  = MB_VSCALE;
        w.cond   = COND_SKIP;
        w.target = UA_SKIP;
      end
      UA_SETPT: begin
        w.dp_op = DP_SETPT;
      end
      UA_ERR: begin
        w.dp_op = DP_ERR;
      end
      UA_PROP: begin
        w.dp_op  = DP_DIFF;
        w.mul_en = 1'b1;
        w.mul_a  = MA_ERR;
        w.mul_b  = MB_PROP;
      end
      UA_DERIV: begin
        w.acc_op = ACC_LOAD;
        w.mul_en = 1'b1;
        w.mul_a  = MA_DIFF;
        w.mul_b  = MB_DERIV;
      end
      UA_INTEG: begin
        w.acc_op = ACC_ADD;
        w.mul_en = 1'b1;
        w.mul_a  = MA_ESUM;
        w.mul_b  = MB_INTEG;
      end
      UA_SUM: begin
        w.acc_op = ACC_ADD;
        w.dp_op  = DP_SUM;
      end
      UA_CLAMP: begin
        w.dp_op  = DP_CLAMP;
        w.mul_en = 1'b1;
        w.mul_a  = MA_SUM;
        w.mul_b  = MB_LEAK;
      end
      UA_ESUM: begin
        w.dp_op  = DP_ESUM;
        w.mul_en = 1'b1;
        w.mul_a  = MA_MAG;
        w.mul_b  = MB_DUTY;
      end
      UA_COMMIT: begin
        w.dp_op = DP_COMMIT;
        w.last  = 1'b1;
      end
      UA_SKIP: begin
        w.dp_op = DP_SKIP_EMIT;
        w.last  = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

  // saturate to the signed 32-bit range
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SAT_IN_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if (v[SAT_IN_W-1:Q_W-1] == '0 || v[SAT_IN_W-1:Q_W-1] == '1) begin
      r = v[Q_W-1:0];
    end else if (v[SAT_IN_W-1]) begin
      r = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(Q_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

/* rtl/core/wepd_if.sv */
// ----------------------------------------------------------------------------
// wepd_in_if / wepd_out_if
// Valid/ready channels for control ticks and drive results.
// ----------------------------------------------------------------------------
interface wepd_in_if;
  import wepd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     wheel;
  logic [ENC_W-1:0]         encoder_count;
  logic signed [TGT_W-1:0]  target_velocity;
  logic [BATT_W-1:0]        battery_mv;

  modport source (output valid, wheel, encoder_count, target_velocity, battery_mv,
                  input ready);
  modport sink   (input valid, wheel, encoder_count, target_velocity, battery_mv,
                  output ready);
endinterface

interface wepd_out_if;
  import wepd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     wheel_out;
  logic [DUTY_W-1:0]        forward_duty;
  logic [DUTY_W-1:0]        backward_duty;
  logic                     drive_enable;
  logic signed [ENC_W-1:0]  step_delta;
  logic signed [POS_W-1:0]  position_count;

  modport source (output valid, wheel_out, forward_duty, backward_duty, drive_enable,
                         step_delta, position_count,
                  input ready);
  modport sink   (input valid, wheel_out, forward_duty, backward_duty, drive_enable,
                        step_delta, position_count,
                  output ready);
endinterface

/* rtl/core/wheel_encoder_pid_drive_core.sv */
// ----------------------------------------------------------------------------
// wheel_encoder_pid_drive_core
// Per-wheel encoder tracking and PID speed loop run by a microcoded sequencer.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  in_ch     in   valid/ready      wheel, encoder_count, target_velocity, battery_mv
//  out_ch    out  valid/ready      wheel_out, forward/backward_duty, drive_enable,
//                                  step_delta, position_count
//  apb       in   psel/penable     gains, leak, velocity scale, battery limit
//
//  a tick is accepted in idle and then runs ten control-store steps, in which the
//  single shared 34x17 multiplier forms six products in turn. a low-battery or
//  unknown-wheel tick jumps straight to the result step.
//  reset loads the register defaults and zeroes all per-wheel state at once.
//  the result step holds while the output register is still full; a new tick is
//  taken only once the sequencer is back at its first step.
// ----------------------------------------------------------------------------
module wheel_encoder_pid_drive_core (
  input  logic                            clk,
  input  logic                            rst,
  wepd_in_if.sink                         in_ch,
  wepd_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [wepd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [wepd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [wepd_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import wepd_pkg::*;

  cfg_t     cfg;
  dp_ctl_t  ctl;
  dp_stat_t stat;

  wepd_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wepd_sequencer u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  wepd_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .ctl    (ctl),
    .stat   (stat),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

/* rtl/core/wepd_apb_regs.sv */
// ----------------------------------------------------------------------------
// wepd_apb_regs
// APB register file holding the loop gains, leak, scale and battery limit.
// ----------------------------------------------------------------------------
module wepd_apb_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [wepd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [wepd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [wepd_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  output wepd_pkg::cfg_t                  cfg
);
  import wepd_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_prop      <= RST_GAIN_PROP;
      cfg.gain_integ     <= RST_GAIN_INTEG;
      cfg.gain_deriv     <= RST_GAIN_DERIV;
      cfg.sum_leak       <= RST_SUM_LEAK;
      cfg.velocity_scale <= RST_VELOCITY_SCALE;
      cfg.low_battery_mv <= RST_LOW_BATTERY_MV;
    end else if (wr_en) begin
      case (idx)
        REG_GAIN_PROP:      cfg.gain_prop      <= pwdata[GAIN_W-1:0];
        REG_GAIN_INTEG:     cfg.gain_integ     <= pwdata[GAIN_W-1:0];
        REG_GAIN_DERIV:     cfg.gain_deriv     <= pwdata[GAIN_W-1:0];
        REG_SUM_LEAK:       cfg.sum_leak       <= pwdata[GAIN_W-1:0];
        REG_VELOCITY_SCALE: cfg.velocity_scale <= pwdata[GAIN_W-1:0];
        REG_LOW_BATTERY_MV: cfg.low_battery_mv <= pwdata[BATT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_GAIN_PROP:      prdata = APB_DATA_W'(cfg.gain_prop);
      REG_GAIN_INTEG:     prdata = APB_DATA_W'(cfg.gain_integ);
      REG_GAIN_DERIV:     prdata = APB_DATA_W'(cfg.gain_deriv);
      REG_SUM_LEAK:       prdata = APB_DATA_W'(cfg.sum_leak);
      REG_VELOCITY_SCALE: prdata = APB_DATA_W'(cfg.velocity_scale);
      REG_LOW_BATTERY_MV: prdata = APB_DATA_W'(cfg.low_battery_mv);
      default:            prdata = '0;
    endcase
  end

endmodule

/* rtl/core/wepd_sequencer.sv */
// ----------------------------------------------------------------------------
// wepd_sequencer
// Step counter over the control store, with the skip jump and output stall.
// ----------------------------------------------------------------------------
module wepd_sequencer (
  input  logic               clk,
  input  logic               rst,
  input  wepd_pkg::dp_stat_t stat,
  output wepd_pkg::dp_ctl_t  ctl
);
  import wepd_pkg::*;

  seq_state_t state, state_next;
  step_t      step, step_next;
  uword_t     uw;

  assign uw = ucode_fetch(step);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
      step  <= UA_DELTA;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    ctl.idle   = 1'b0;
    ctl.exec   = 1'b0;
    ctl.uw     = uw;
    case (state)
      SEQ_IDLE: begin
        ctl.idle = 1'b1;
        if (stat.in_valid) begin
          state_next = SEQ_RUN;
          step_next  = UA_DELTA;
        end
      end
      SEQ_RUN: begin
        // the result step waits for room in the output register
        if (!(uw.last && stat.out_busy)) begin
          ctl.exec = 1'b1;
          if (uw.last) begin
            state_next = SEQ_IDLE;
            step_next  = UA_DELTA;
          end else if (uw.cond == COND_SKIP && stat.skip) begin
            step_next = uw.target;
          end else begin
            step_next = step + STEP_W'(1);
          end
        end
      end
      default: begin
        state_next = SEQ_IDLE;
        step_next  = UA_DELTA;
      end
    endcase
  end

  a_idle_at_top: assert property (@(posedge clk) disable iff (rst)
    state == SEQ_IDLE |-> step == UA_DELTA)
    else $error("sequencer idle away from the first step");

  a_step_in_program: assert property (@(posedge clk) disable iff (rst)
    state == SEQ_RUN |-> step < STEP_W'(UCODE_LEN))
    else $error("step counter ran past the control store");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (state == SEQ_RUN && uw.last && !stat.out_busy) |=> state == SEQ_IDLE)
    else $error("sequencer did not finish after the result step");

endmodule

/* rtl/core/wepd_datapath.sv */
// ----------------------------------------------------------------------------
// wepd_datapath
// Shared multiplier, accumulator, per-wheel state and result register.
// ----------------------------------------------------------------------------
module wepd_datapath (
  input  logic               clk,
  input  logic               rst,
  input  wepd_pkg::cfg_t     cfg,
  input  wepd_pkg::dp_ctl_t  ctl,
  output wepd_pkg::dp_stat_t stat,
  wepd_in_if.sink            in_ch,
  wepd_out_if.source         out_ch
);
  import wepd_pkg::*;

  // per-wheel loop state
  logic [ENC_W-1:0]        prev_count  [WHEELS];
  logic signed [Q_W-1:0]   setpoint    [WHEELS];
  logic signed [Q_W-1:0]   prev_err    [WHEELS];
  logic signed [Q_W-1:0]   error_sum   [WHEELS];
  logic signed [POS_W-1:0] position    [WHEELS];

  // latched tick
  logic                    wheel_r;
  logic [ENC_W-1:0]        count_r;
  logic signed [TGT_W-1:0] target_r;
  logic [BATT_W-1:0]       batt_r;

  // working registers
  logic signed [ENC_W-1:0]   delta_r;
  logic signed [Q_W-1:0]     sp_r;
  logic signed [Q_W-1:0]     err_r;
  logic signed [DIFF_W-1:0]  diff_r;
  logic signed [Q_W-1:0]     sum_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      u_neg;
  logic [MAG_W-1:0]          u_mag;
  logic signed [PROD_W-1:0]  prod;

  logic                      out_valid;

  logic [WIDX_W-1:0]           widx;
  logic                        load;
  logic                        low;
  logic                        beyond;
  logic signed [MUL_A_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0]   mul_b;
  logic signed [PROD_W-FRAC_W-1:0] prod_sh;
  logic signed [POS_W-1:0]     pos_sum;
  logic [DUTY_W-1:0]           duty;
  logic signed [ACC_W-1:0]     acc_neg;
  logic                        clamp_neg;
  logic [MAG_W-1:0]            clamp_mag;
  logic signed [Q_W-1:0]       delta_sh;

  localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(65536);
  localparam logic signed [ACC_W-1:0] ACC_LO = -ACC_HI;

  assign widx   = WIDX_W'(wheel_r);
  assign load   = in_ch.valid && in_ch.ready;
  assign low    = batt_r < cfg.low_battery_mv;
  assign beyond = 32'(wheel_r) >= 32'(WHEELS);

  // no transfer is taken while reset holds the sequencer
  assign in_ch.ready   = ctl.idle && !rst;
  assign stat.in_valid = in_ch.valid;
  assign stat.skip     = low || beyond;
  assign stat.out_busy = out_valid && !out_ch.ready;

  assign out_ch.valid = out_valid;

  assign prod_sh  = prod[PROD_W-1:FRAC_W];
  assign pos_sum  = position[widx] + POS_W'(delta_r);
  assign duty     = prod[FRAC_W+DUTY_W-1:FRAC_W];
  assign acc_neg  = -acc_r;
  assign delta_sh = {delta_r, {FRAC_W{1'b0}}};

  // operand select for the shared multiplier
  always_comb begin
    case (ctl.uw.mul_a)
      MA_TARGET: mul_a = MUL_A_W'(target_r);
      MA_ERR:    mul_a = MUL_A_W'(err_r);
      MA_DIFF:   mul_a = MUL_A_W'(diff_r);
      MA_ESUM:   mul_a = MUL_A_W'(error_sum[widx]);
      MA_SUM:    mul_a = MUL_A_W'(sum_r);
      MA_MAG:    mul_a = $signed({{(MUL_A_W-MAG_W){1'b0}}, u_mag});
      default:   mul_a = '0;
    endcase
    case (ctl.uw.mul_b)
      MB_VSCALE: mul_b = $signed({1'b0, cfg.velocity_scale});
      MB_PROP:   mul_b = $signed({1'b0, cfg.gain_prop});
      MB_DERIV:  mul_b = $signed({1'b0, cfg.gain_deriv});
      MB_INTEG:  mul_b = $signed({1'b0, cfg.gain_integ});
      MB_LEAK:   mul_b = $signed({1'b0, cfg.sum_leak});
      MB_DUTY:   mul_b = $signed(DUTY_FULL);
      default:   mul_b = '0;
    endcase
  end

  // clamp to plus or minus one and split into sign and magnitude
  always_comb begin
    clamp_neg = acc_r[ACC_W-1];
    if (!clamp_neg) begin
      clamp_mag = (acc_r > ACC_HI) ? U_LIMIT : acc_r[MAG_W-1:0];
    end else begin
      clamp_mag = (acc_r < ACC_LO) ? U_LIMIT : acc_neg[MAG_W-1:0];
    end
  end

  // tick latch and working registers
  always_ff @(posedge clk) begin
    if (load) begin
      wheel_r  <= in_ch.wheel;
      count_r  <= in_ch.encoder_count;
      target_r <= in_ch.target_velocity;
      batt_r   <= in_ch.battery_mv;
    end
    if (ctl.exec) begin
      if (ctl.uw.mul_en) begin
        prod <= mul_a * mul_b;
      end
      case (ctl.uw.acc_op)
        ACC_LOAD: acc_r <= ACC_W'(prod_sh);
        ACC_ADD:  acc_r <= acc_r + ACC_W'(prod_sh);
        default:  ;
      endcase
      case (ctl.uw.dp_op)
        DP_DELTA: delta_r <= $signed(count_r - prev_count[widx]);
        DP_SETPT: sp_r    <= sat_q(SAT_IN_W'(setpoint[widx])
                                   + $signed(prod[SAT_IN_W+STEP_SH-1:STEP_SH]));
        DP_ERR:   err_r   <= sat_q(SAT_IN_W'(sp_r) - SAT_IN_W'(delta_sh));
        DP_DIFF:  diff_r  <= DIFF_W'(err_r) - DIFF_W'(prev_err[widx]);
        DP_SUM:   sum_r   <= sat_q(SAT_IN_W'(error_sum[widx]) + SAT_IN_W'(err_r));
        DP_CLAMP: begin
          u_neg <= clamp_neg;
          u_mag <= clamp_mag;
        end
        DP_ESUM:  sum_r   <= $signed(prod[Q_W+FRAC_W-1:FRAC_W]);
        DP_COMMIT: begin
          out_ch.wheel_out      <= wheel_r;
          out_ch.forward_duty   <= u_neg ? '0 : duty;
          out_ch.backward_duty  <= u_neg ? duty : '0;
          out_ch.drive_enable   <= 1'b1;
          out_ch.step_delta     <= delta_r;
          out_ch.position_count <= pos_sum;
        end
        DP_SKIP_EMIT: begin
          out_ch.wheel_out      <= wheel_r;
          out_ch.forward_duty   <= '0;
          out_ch.backward_duty  <= '0;
          out_ch.drive_enable   <= !low;
          out_ch.step_delta     <= '0;
          out_ch.position_count <= beyond ? '0 : position[widx];
        end
        default: ;
      endcase
    end
  end

  // per-wheel state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int k = 0; k < WHEELS; k++) begin
        prev_count[k] <= '0;
        setpoint[k]   <= '0;
        prev_err[k]   <= '0;
        error_sum[k]  <= '0;
        position[k]   <= '0;
      end
    end else begin
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (ctl.exec && ctl.uw.dp_op == DP_COMMIT) begin
        prev_count[widx] <= count_r;
        setpoint[widx]   <= err_r;
        prev_err[widx]   <= err_r;
        error_sum[widx]  <= sum_r;
        position[widx]   <= pos_sum;
        out_valid        <= 1'b1;
      end
      if (ctl.exec && ctl.uw.dp_op == DP_SKIP_EMIT) begin
        out_valid <= 1'b1;
      end
    end
  end

  a_no_emit_when_full: assert property (@(posedge clk) disable iff (rst)
    (ctl.exec && ctl.uw.last) |-> !stat.out_busy)
    else $error("result written over one not yet transferred");

  a_clamp_range: assert property (@(posedge clk) disable iff (rst)
    (ctl.exec && ctl.uw.dp_op == DP_CLAMP) |=> u_mag <= U_LIMIT)
    else $error("drive magnitude beyond full scale");

endmodule

/* tb/wheel_encoder_pid_drive_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wheel_encoder_pid_drive_core_tb
// Drives control ticks for both wheels through several register settings and
// checks every drive result against a cycle-free model of the speed loop.
// ----------------------------------------------------------------------------
module wheel_encoder_pid_drive_core_tb;
  import wepd_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic                    wheel;
    logic [ENC_W-1:0]        enc;
    logic signed [TGT_W-1:0] tgt;
    logic [BATT_W-1:0]       batt;
  } tick_t;

  typedef struct packed {
    logic                    wheel_out;
    logic [DUTY_W-1:0]       fwd;
    logic [DUTY_W-1:0]       bwd;
    logic                    drive_enable;
    logic signed [ENC_W-1:0] step_delta;
    logic signed [POS_W-1:0] position_count;
  } drive_res_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata, prdata;

  wepd_in_if  tick_ch ();
  wepd_out_if drive_ch ();

  wheel_encoder_pid_drive_core uut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (tick_ch),
    .out_ch  (drive_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // model copy of the registers
  logic [GAIN_W-1:0] kp, ki, kd, leak, vscale;
  logic [BATT_W-1:0] batt_min;

  // model copy of the per-wheel loop state
  logic [ENC_W-1:0]        prev_count [WHEELS];
  logic signed [Q_W-1:0]   setpt      [WHEELS];
  logic signed [Q_W-1:0]   prev_err   [WHEELS];
  logic signed [Q_W-1:0]   err_sum    [WHEELS];
  logic [POS_W-1:0]        wheel_pos  [WHEELS];

  tick_t      tick_q[$];
  drive_res_t drive_results_q[$];

  // stimulus-side tracking so random counts follow a plausible wheel motion
  logic [ENC_W-1:0]        gen_count  [WHEELS];
  logic signed [TGT_W-1:0] gen_target [WHEELS];

  bit tick_taken;
  bit steady;
  int mismatches;
  int cycles;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic drive_res_t wheel_loop_step(tick_t t);
    drive_res_t r;
    logic [ENC_W-1:0] draw;
    int w;
    longint delta, steps, sp, err, p, d, i, sum, u;
    w = int'(t.wheel);
    r = '0;
    r.wheel_out = t.wheel;
    r.drive_enable = (t.batt >= batt_min);
    if (!r.drive_enable) begin
      // low battery: outputs parked, state frozen
      r.position_count = wheel_pos[w];
      return r;
    end
    draw = t.enc - prev_count[w];
    delta = longint'($signed(draw));
    prev_count[w] = t.enc;
    wheel_pos[w] = wheel_pos[w] + POS_W'(delta);

    steps = (longint'(t.tgt) * longint'(vscale)) >>> STEP_SH;
    sp = clamp32(longint'(setpt[w]) + steps);
    err = clamp32(sp - delta * 65536);

    p = (err * longint'(kp)) >>> 16;
    d = ((err - longint'(prev_err[w])) * longint'(kd)) >>> 16;
    i = (longint'(err_sum[w]) * longint'(ki)) >>> 16;

    setpt[w] = Q_W'(err);
    prev_err[w] = Q_W'(err);
    sum = clamp32(longint'(err_sum[w]) + err);
    err_sum[w] = Q_W'((sum * longint'(leak)) >>> 16);

    u = p + i + d;
    if (u > 65536) u = 65536;
    if (u < -65536) u = -65536;
    if (u >= 0) begin
      r.fwd = DUTY_W'((u * 1023) >>> 16);
    end else begin
      r.bwd = DUTY_W'(((-u) * 1023) >>> 16);
    end
    r.step_delta = ENC_W'(delta);
    r.position_count = wheel_pos[w];
    return r;
  endfunction

  task automatic compare_field(string fname, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, want, got);
    end
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [APB_DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_GAIN_PROP:      kp       = val[GAIN_W-1:0];
      REG_GAIN_INTEG:     ki       = val[GAIN_W-1:0];
      REG_GAIN_DERIV:     kd       = val[GAIN_W-1:0];
      REG_SUM_LEAK:       leak     = val[GAIN_W-1:0];
      REG_VELOCITY_SCALE: vscale   = val[GAIN_W-1:0];
      REG_LOW_BATTERY_MV: batt_min = val[BATT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_config(int p, int i, int d, int lk, int vs, int bmin);
    cfg_write(REG_GAIN_PROP, p);
    cfg_write(REG_GAIN_INTEG, i);
    cfg_write(REG_GAIN_DERIV, d);
    cfg_write(REG_SUM_LEAK, lk);
    cfg_write(REG_VELOCITY_SCALE, vs);
    cfg_write(REG_LOW_BATTERY_MV, bmin);
  endtask

  task automatic push_tick(int w, int enc, int tgt, int batt);
    tick_t t;
    t.wheel = w[0];
    t.enc   = ENC_W'(enc);
    t.tgt   = TGT_W'(tgt);
    t.batt  = BATT_W'(batt);
    gen_count[w] = t.enc;
    tick_q.push_back(t);
  endtask

  task automatic gen_ticks(int n);
    int w, r, enc, tgt, batt;
    for (int k = 0; k < n; k++) begin
      w = $urandom_range(WHEELS - 1);
      r = $urandom_range(99);
      if (r < 70) begin
        enc = int'(gen_count[w]) + int'($urandom_range(400)) - 200;
      end else begin
        enc = $urandom_range(16'hFFFF);
      end
      // hold the speed command for a while, then move it
      if ($urandom_range(99) < 10) begin
        if ($urandom_range(99) < 70) begin
          gen_target[w] = TGT_W'(int'($urandom_range(2048)) - 1024);
        end else begin
          gen_target[w] = TGT_W'($urandom);
        end
      end
      tgt = gen_target[w];
      r = $urandom_range(99);
      if (r < 15 && batt_min != 0) begin
        batt = $urandom_range(int'(batt_min) - 1);
      end else if (r < 20) begin
        batt = batt_min;
      end else begin
        batt = $urandom_range(16383, int'(batt_min));
      end
      push_tick(w, enc, tgt, batt);
    end
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (tick_q.size() != 0 || tick_ch.valid || drive_results_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // tick driver
  always @(negedge clk) begin : tick_driver
    tick_t nxt;
    if (!rst && (!tick_ch.valid || tick_taken)) begin
      if (tick_q.size() != 0 && (steady || $urandom_range(99) >= 18)) begin
        nxt = tick_q.pop_front();
        tick_ch.valid           <= 1'b1;
        tick_ch.wheel           <= nxt.wheel;
        tick_ch.encoder_count   <= nxt.enc;
        tick_ch.target_velocity <= nxt.tgt;
        tick_ch.battery_mv      <= nxt.batt;
      end else begin
        tick_ch.valid <= 1'b0;
      end
    end
  end

  // result sink stalls
  always @(negedge clk) begin
    drive_ch.ready <= steady || ($urandom_range(99) >= 18);
  end

  // transfer monitor and prediction
  always @(posedge clk) begin : monitor
    tick_t t;
    drive_res_t want;
    cycles++;
    tick_taken <= !rst && tick_ch.valid && tick_ch.ready;
    if (!rst && tick_ch.valid && tick_ch.ready) begin
      t.wheel = tick_ch.wheel;
      t.enc   = tick_ch.encoder_count;
      t.tgt   = tick_ch.target_velocity;
      t.batt  = tick_ch.battery_mv;
      drive_results_q.push_back(wheel_loop_step(t));
    end
    if (!rst && drive_ch.valid && drive_ch.ready) begin
      if (drive_results_q.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, actual wheel %0d fwd %0d bwd %0d",
                 $time, drive_ch.wheel_out, drive_ch.forward_duty, drive_ch.backward_duty);
      end else begin
        want = drive_results_q.pop_front();
        compare_field("wheel_out", want.wheel_out, drive_ch.wheel_out);
        compare_field("forward_duty", want.fwd, drive_ch.forward_duty);
        compare_field("backward_duty", want.bwd, drive_ch.backward_duty);
        compare_field("drive_enable", want.drive_enable, drive_ch.drive_enable);
        compare_field("step_delta", POS_W'(want.step_delta), POS_W'(drive_ch.step_delta));
        compare_field("position_count", want.position_count, drive_ch.position_count);
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("wheel_encoder_pid_drive_core_tb failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tick_ch.valid = 1'b0;
    tick_ch.wheel = 1'b0;
    tick_ch.encoder_count = '0;
    tick_ch.target_velocity = '0;
    tick_ch.battery_mv = '0;
    drive_ch.ready = 1'b0;
    steady = 1'b0;
    mismatches = 0;
    cycles = 0;
    kp = RST_GAIN_PROP;
    ki = RST_GAIN_INTEG;
    kd = RST_GAIN_DERIV;
    leak = RST_SUM_LEAK;
    vscale = RST_VELOCITY_SCALE;
    batt_min = RST_LOW_BATTERY_MV;
    for (int w = 0; w < WHEELS; w++) begin
      prev_count[w] = '0;
      setpt[w] = '0;
      prev_err[w] = '0;
      err_sum[w] = '0;
      wheel_pos[w] = '0;
      gen_count[w] = '0;
      gen_target[w] = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed ticks under the reset register values
    push_tick(0, 0, 0, 16383);
    push_tick(0, 100, 32767, 3000);           // battery exactly at the limit
    push_tick(1, 65535, -32768, 5000);        // count wraps backward by one
    push_tick(1, 32766, 0, 2999);             // battery just under the limit
    push_tick(1, 32766, 256, 0);              // empty battery
    push_tick(1, 32766, 256, 9000);           // largest forward step
    push_tick(0, 32868, -32768, 12000);       // largest backward step
    push_tick(0, 32868, 32767, 8000);
    push_tick(0, 32868, 32767, 8000);
    push_tick(0, 32868, 32767, 8000);
    push_tick(0, 65535, 32767, 8000);         // error pushed toward the negative rail
    push_tick(0, 32766, 32767, 8000);         // error past the negative rail
    push_tick(0, 32766, 32767, 8000);
    push_tick(1, 16'hAAAA, 16'h5555, 14'h2AAA);
    push_tick(1, 16'h5555, 16'hAAAA, 14'h1555);
    push_tick(1, 16'h5555, -256, 3500);
    push_tick(1, 16'h5500, -256, 3500);
    push_tick(0, 32700, 0, 3001);
    push_tick(0, 32800, 0, 3001);
    push_tick(1, 0, 1, 16383);
    push_tick(1, 0, -1, 16383);
    push_tick(0, 0, -32768, 2000);
    push_tick(0, 1, 0, 16383);
    wait_idle();

    // largest gains, nothing counts as low battery
    load_config(65535, 65535, 65535, 65535, 65535, 0);
    gen_ticks(250);
    wait_idle();

    // all gains zero, every battery but the top one is low
    load_config(0, 0, 0, 0, 0, 16383);
    gen_ticks(120);
    wait_idle();

    // back to the reset values with no stalls on either side
    load_config(RST_GAIN_PROP, RST_GAIN_INTEG, RST_GAIN_DERIV, RST_SUM_LEAK,
                RST_VELOCITY_SCALE, RST_LOW_BATTERY_MV);
    steady = 1'b1;
    gen_ticks(300);
    wait_idle();
    steady = 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      load_config($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                  $urandom_range(65535), $urandom_range(65535), $urandom_range(12000));
      gen_ticks(220);
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("wheel_encoder_pid_drive_core_tb passed");
    end else begin
      $display("wheel_encoder_pid_drive_core_tb failed");
    end
    $finish;
  end

endmodule
